// File: rtl/bilinear_image_sampler_assert.svh
// Assertion macros used by the bilinear image sampler checker.
// Each macro expands to one labelled concurrent assertion that is disabled while reset is high.
`ifndef BILINEAR_IMAGE_SAMPLER_ASSERT_SVH
`define BILINEAR_IMAGE_SAMPLER_ASSERT_SVH

// Both conditions are checked in the same cycle.
`define BIS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bilinear image sampler: same-cycle check failed");

// The consequence is checked in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bilinear image sampler: next-cycle check failed");

`endif

// File: rtl/bis_pkg.sv
`timescale 1ns / 1ps

package bis_pkg;

   // Coordinate format and payload widths.
   localparam int FRAC_BITS   = 8;
   localparam int COORD_W     = 18;
   localparam int PIX_W       = 8;
   localparam int VALUE_W     = 17;
   localparam int SIZE_REG_W  = 9;

   // Stream and register port widths.
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Field positions inside req_tdata.
   localparam int COL_LSB     = 0;
   localparam int ROW_LSB     = COL_LSB + PIX_W;
   localparam int VALUE_LSB   = ROW_LSB + PIX_W;
   localparam int SX_LSB      = VALUE_LSB + PIX_W;
   localparam int SY_LSB      = SX_LSB + COORD_W;

   // Request kinds carried on req_tuser.
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Register indexes, taken from csr_paddr[2].
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam int SIZE_RESET = 256;
   localparam int MIN_SIZE   = 2;

   // Interpolation arithmetic.
   localparam int                  WEIGHT_W  = 2 * FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0]  FRAC_ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam int                  SUM_W     = PIX_W + 2 * FRAC_BITS;

   // Division by 255 with rounding: q = floor((sum + 127) / 255), done as a
   // reciprocal multiply that may come out one low, then one correction step.
   localparam logic [SUM_W-1:0]    ROUND_BIAS  = SUM_W'(127);
   localparam logic [SUM_W-1:0]    DIVISOR     = SUM_W'(255);
   localparam int                  DIV_SHIFT   = 8;
   localparam int                  RECIP_W     = 17;
   localparam logic [RECIP_W-1:0]  RECIP_255   = RECIP_W'(65793);
   localparam int                  RECIP_SHIFT = SUM_W;
   localparam int                  QPROD_W     = SUM_W + RECIP_W;

endpackage

// File: rtl/bis_ram.sv
`timescale 1ns / 1ps

module bis_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, read-first; read data held while the port is not enabled.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bilinear_image_sampler.sv
// Bilinear image sampler: each sample request gives its result on rsp, in request order;
// pixel-write requests give none. Throughput is one request per cycle without rsp stalls.
// The image lies in four RAM banks with registered read data, split by row and column parity.
// Each sample reads its four neighbours from the four banks in parallel.
// Reset (synchronous, active high) empties the pipeline and sets both sizes to 256.
// The image store is not cleared: a pixel reads as undefined until it has been written.
`timescale 1ns / 1ps

module bilinear_image_sampler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: pixel_col, pixel_row, pixel_value, sample_x, sample_y (lowest bits first)
   input  logic [bis_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: kind
   input  logic                              req_tuser,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: sample_value
   output logic [bis_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bis_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bis_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bis_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   import bis_pkg::*;

   // Pixel coordinate widths and the geometry of each parity bank.
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int BANK_W      = (MAX_WIDTH + 1) / 2;
   localparam int BANK_H      = (MAX_HEIGHT + 1) / 2;
   localparam int BCOL_W      = (BANK_W > 1) ? $clog2(BANK_W) : 1;
   localparam int BROW_W      = (BANK_H > 1) ? $clog2(BANK_H) : 1;
   localparam int BANK_DEPTH  = BANK_W * BANK_H;
   localparam int BA_W        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int NUM_BANKS   = 4;
   localparam int NUM_STAGES  = 8;

   // Unsigned width in which a non-negative coordinate is compared with its limit.
   localparam int XU_W = (COL_W + FRAC_BITS > COORD_W - 1) ? COL_W + FRAC_BITS : COORD_W - 1;
   localparam int YU_W = (ROW_W + FRAC_BITS > COORD_W - 1) ? ROW_W + FRAC_BITS : COORD_W - 1;

   localparam int WIDTH_RESET  = (SIZE_RESET < MAX_WIDTH) ? SIZE_RESET : MAX_WIDTH;
   localparam int HEIGHT_RESET = (SIZE_RESET < MAX_HEIGHT) ? SIZE_RESET : MAX_HEIGHT;

   // Contents of the first stage: either a pixel write or a decoded sample.
   typedef struct packed {
      logic                 is_write;
      logic                 wr_ok;
      logic [1:0]           wr_bank;
      logic [BA_W-1:0]      wr_addr;
      logic [PIX_W-1:0]     wr_value;
      logic [COL_W-1:0]     lx;
      logic [ROW_W-1:0]     ly;
      logic [FRAC_BITS-1:0] s;
      logic [FRAC_BITS-1:0] t;
   } s1_type;

   // Location of a pixel inside its bank: half-row times bank width plus half-column.
   function automatic logic [BA_W-1:0] bank_addr(input logic [BROW_W-1:0] row_half,
                                                 input logic [BCOL_W-1:0] col_half);
      return BA_W'(row_half) * BA_W'(BANK_W) + BA_W'(col_half);
   endfunction

   // ------------------------------------------------------------------
   // Register port. The user must see that both sizes are written only while the block is
   // idle; the block does not enforce it. Alongside each raw register sits the clamp limit
   // (size minus two), computed from the size saturated to the range 2 to the store size.
   // ------------------------------------------------------------------
   logic                  csr_write;
   logic [SIZE_REG_W-1:0] csr_wval;
   logic [SIZE_REG_W-1:0] width_reg_ff, width_reg_in;
   logic [SIZE_REG_W-1:0] height_reg_ff, height_reg_in;
   logic [COL_W-1:0]      x_limit_ff, x_limit_in;
   logic [ROW_W-1:0]      y_limit_ff, y_limit_in;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_wval   = csr_pwdata[SIZE_REG_W-1:0];

   always_comb begin
      width_reg_in  = width_reg_ff;
      height_reg_in = height_reg_ff;
      x_limit_in    = x_limit_ff;
      y_limit_in    = y_limit_ff;
      if (csr_write && csr_paddr[2] == REG_IMAGE_WIDTH) begin
         width_reg_in = csr_wval;
         if (csr_wval < SIZE_REG_W'(MIN_SIZE)) begin
            x_limit_in = '0;
         end else if (32'(csr_wval) > 32'(MAX_WIDTH)) begin
            x_limit_in = COL_W'(MAX_WIDTH - MIN_SIZE);
         end else begin
            x_limit_in = COL_W'(csr_wval - SIZE_REG_W'(MIN_SIZE));
         end
      end
      if (csr_write && csr_paddr[2] == REG_IMAGE_HEIGHT) begin
         height_reg_in = csr_wval;
         if (csr_wval < SIZE_REG_W'(MIN_SIZE)) begin
            y_limit_in = '0;
         end else if (32'(csr_wval) > 32'(MAX_HEIGHT)) begin
            y_limit_in = ROW_W'(MAX_HEIGHT - MIN_SIZE);
         end else begin
            y_limit_in = ROW_W'(csr_wval - SIZE_REG_W'(MIN_SIZE));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= SIZE_REG_W'(SIZE_RESET);
         height_reg_ff <= SIZE_REG_W'(SIZE_RESET);
         x_limit_ff    <= COL_W'(WIDTH_RESET - MIN_SIZE);
         y_limit_ff    <= ROW_W'(HEIGHT_RESET - MIN_SIZE);
      end else begin
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         x_limit_ff    <= x_limit_in;
         y_limit_ff    <= y_limit_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_reg_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_reg_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. Each stage has a valid bit and takes new
   // contents whenever it is empty or its contents move on, so empty
   // stages close up behind a stalled result and requests keep coming in
   // until the pipeline is really full.
   // ------------------------------------------------------------------
   logic [NUM_STAGES:1] valid_ff, valid_in;
   logic [NUM_STAGES:1] load;

   assign load[NUM_STAGES] = ~valid_ff[NUM_STAGES] | rsp_tready;
   for (genvar k = 1; k < NUM_STAGES; k++) begin : g_load
      assign load[k] = ~valid_ff[k] | load[k + 1];
   end

   assign req_tready = load[1];

   // ------------------------------------------------------------------
   // Stage 1: unpack the request, decode a pixel write, or clamp and split
   // the sample coordinates into integer part and fraction.
   // ------------------------------------------------------------------
   logic [PIX_W-1:0]          req_col, req_row, req_value;
   logic signed [COORD_W-1:0] req_x, req_y;
   logic [XU_W-1:0]           x_mag, x_top, x_clamp;
   logic [YU_W-1:0]           y_mag, y_top, y_clamp;
   s1_type                    s1_ff, s1_in;

   assign req_col   = req_tdata[COL_LSB +: PIX_W];
   assign req_row   = req_tdata[ROW_LSB +: PIX_W];
   assign req_value = req_tdata[VALUE_LSB +: PIX_W];
   assign req_x     = req_tdata[SX_LSB +: COORD_W];
   assign req_y     = req_tdata[SY_LSB +: COORD_W];

   always_comb begin
      x_mag = XU_W'(req_x[COORD_W-2:0]);
      x_top = XU_W'({x_limit_ff, {FRAC_BITS{1'b0}}});
      if (req_x[COORD_W-1]) begin
         x_clamp = '0;
      end else if (x_mag > x_top) begin
         x_clamp = x_top;
      end else begin
         x_clamp = x_mag;
      end

      y_mag = YU_W'(req_y[COORD_W-2:0]);
      y_top = YU_W'({y_limit_ff, {FRAC_BITS{1'b0}}});
      if (req_y[COORD_W-1]) begin
         y_clamp = '0;
      end else if (y_mag > y_top) begin
         y_clamp = y_top;
      end else begin
         y_clamp = y_mag;
      end

      s1_in.is_write = (req_tuser == KIND_WRITE);
      // Writes outside the store are dropped; writes beyond the size in use are kept.
      s1_in.wr_ok    = (32'(req_col) < 32'(MAX_WIDTH)) && (32'(req_row) < 32'(MAX_HEIGHT));
      s1_in.wr_bank  = {req_row[0], req_col[0]};
      s1_in.wr_addr  = bank_addr(BROW_W'(req_row >> 1), BCOL_W'(req_col >> 1));
      s1_in.wr_value = req_value;
      s1_in.lx       = x_clamp[FRAC_BITS +: COL_W];
      s1_in.ly       = y_clamp[FRAC_BITS +: ROW_W];
      s1_in.s        = x_clamp[FRAC_BITS-1:0];
      s1_in.t        = y_clamp[FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s1_ff <= s1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: bank access. A write goes to the one bank its parity picks.
   // A sample reads all four banks: each bank holds exactly one of the
   // four neighbours, at the column and row of matching parity. Writes and
   // reads both happen as the stage-1 request moves on, so they keep
   // request order and no forwarding is needed.
   // ------------------------------------------------------------------
   logic [BA_W-1:0]  rd_addr   [NUM_BANKS];
   logic [BA_W-1:0]  port_addr [NUM_BANKS];
   logic             bank_we   [NUM_BANKS];
   logic [PIX_W-1:0] bank_rdata[NUM_BANKS];

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      localparam logic COL_PAR = logic'(b % 2);
      localparam logic ROW_PAR = logic'(b / 2);

      logic [COL_W:0] col_use;
      logic [ROW_W:0] row_use;

      assign col_use = (COL_W + 1)'(s1_ff.lx) + (COL_W + 1)'(s1_ff.lx[0] ^ COL_PAR);
      assign row_use = (ROW_W + 1)'(s1_ff.ly) + (ROW_W + 1)'(s1_ff.ly[0] ^ ROW_PAR);
      assign rd_addr[b] = bank_addr(BROW_W'(row_use >> 1), BCOL_W'(col_use >> 1));

      assign bank_we[b]   = valid_ff[1] & s1_ff.is_write & s1_ff.wr_ok & load[2]
                            & (s1_ff.wr_bank == 2'(b));
      assign port_addr[b] = s1_ff.is_write ? s1_ff.wr_addr : rd_addr[b];

      bis_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock (clock),
         .en    (load[2]),
         .we    (bank_we[b]),
         .addr  (port_addr[b]),
         .wdata (s1_ff.wr_value),
         .rdata (bank_rdata[b])
      );
   end

   logic                 s2_lx0_ff, s2_ly0_ff;
   logic [FRAC_BITS-1:0] s2_s_ff, s2_t_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s2_lx0_ff <= s1_ff.lx[0];
         s2_ly0_ff <= s1_ff.ly[0];
         s2_s_ff   <= s1_ff.s;
         s2_t_ff   <= s1_ff.t;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: route the bank outputs to neighbour order and form the four
   // weights. Neighbour i sits at column offset i%2 and row offset i/2.
   // Stage 4: multiply each weight by its pixel.
   // ------------------------------------------------------------------
   logic [FRAC_BITS:0]  s_inv, t_inv;
   logic [PIX_W-1:0]    s3_pix_ff    [NUM_BANKS];
   logic [WEIGHT_W-1:0] s3_weight_ff [NUM_BANKS];
   logic [SUM_W-1:0]    s4_prod_ff   [NUM_BANKS];

   assign s_inv = FRAC_ONE - (FRAC_BITS + 1)'(s2_s_ff);
   assign t_inv = FRAC_ONE - (FRAC_BITS + 1)'(s2_t_ff);

   for (genvar i = 0; i < NUM_BANKS; i++) begin : g_tap
      localparam logic DX = logic'(i % 2);
      localparam logic DY = logic'(i / 2);

      logic [FRAC_BITS:0] fx, fy;

      assign fx = DX ? (FRAC_BITS + 1)'(s2_s_ff) : s_inv;
      assign fy = DY ? (FRAC_BITS + 1)'(s2_t_ff) : t_inv;

      always_ff @(posedge clock) begin
         if (load[3]) begin
            s3_pix_ff[i]    <= bank_rdata[{s2_ly0_ff ^ DY, s2_lx0_ff ^ DX}];
            s3_weight_ff[i] <= WEIGHT_W'(fx) * WEIGHT_W'(fy);
         end
         if (load[4]) begin
            s4_prod_ff[i] <= SUM_W'(s3_weight_ff[i]) * SUM_W'(s3_pix_ff[i]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stages 5 and 6: add the products in two levels; the rounding bias
   // joins the final add. The weights sum to one, so the total fits.
   // Stage 7: reciprocal multiply, a quotient that is exact or one low.
   // Stage 8: one correction step into the result register.
   // ------------------------------------------------------------------
   logic [SUM_W-1:0]   s5_pair_ff [2];
   logic [SUM_W-1:0]   s6_sum_ff;
   logic [QPROD_W-1:0] q_prod;
   logic [SUM_W-1:0]   s7_sum_ff;
   logic [VALUE_W-1:0] s7_quot_ff;
   logic [SUM_W-1:0]   remainder;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   assign q_prod = QPROD_W'(s6_sum_ff) * QPROD_W'(RECIP_255);

   // The remainder is known to lie between 0 and 509, so modular width suffices.
   assign remainder    = s7_sum_ff - (SUM_W'(s7_quot_ff) << DIV_SHIFT) + SUM_W'(s7_quot_ff);
   assign rsp_value_in = s7_quot_ff + VALUE_W'(remainder >= DIVISOR);

   always_ff @(posedge clock) begin
      if (load[5]) begin
         s5_pair_ff[0] <= s4_prod_ff[0] + s4_prod_ff[1];
         s5_pair_ff[1] <= s4_prod_ff[2] + s4_prod_ff[3];
      end
      if (load[6]) begin
         s6_sum_ff <= s5_pair_ff[0] + s5_pair_ff[1] + ROUND_BIAS;
      end
      if (load[7]) begin
         s7_sum_ff  <= s6_sum_ff;
         s7_quot_ff <= q_prod[RECIP_SHIFT +: VALUE_W];
      end
      if (load[8]) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   // Valid bits: writes leave the pipeline once they reach the banks.
   always_comb begin
      valid_in[1] = load[1] ? req_tvalid : valid_ff[1];
      valid_in[2] = load[2] ? (valid_ff[1] & ~s1_ff.is_write) : valid_ff[2];
      for (int k = 3; k <= NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff[NUM_STAGES];
   assign rsp_tdata  = RSP_TDATA_W'(rsp_value_ff);

endmodule

// File: rtl/bis_checker.sv
`timescale 1ns / 1ps

`include "bilinear_image_sampler_assert.svh"

module bis_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bis_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [bis_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input logic [bis_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input logic [bis_pkg::CSR_DATA_W-1:0]    csr_prdata,
   input logic                              csr_pready
);

   import bis_pkg::*;

   localparam logic [CSR_DATA_W-1:0] SIZE_MASK = CSR_DATA_W'({SIZE_REG_W{1'b1}});

   logic                  csr_write;
   logic                  csr_read;
   logic                  rsp_stall;
   logic                  readback_due;
   logic                  csr_wrote_ff;
   logic [CSR_ADDR_W-1:0] csr_waddr_ff;
   logic [CSR_DATA_W-1:0] csr_wdata_ff;

   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_read  = csr_psel & ~csr_pwrite;
   assign rsp_stall = rsp_tvalid & ~rsp_tready;

   // The last register write is registered, so that a read in the cycle after it
   // can be compared with the size bits that were written.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_wrote_ff <= 1'b0;
      end else begin
         csr_wrote_ff <= csr_write;
      end
      csr_waddr_ff <= csr_paddr;
      csr_wdata_ff <= csr_pwdata & SIZE_MASK;
   end

   assign readback_due = csr_wrote_ff & csr_read & (csr_paddr == csr_waddr_ff);

   // A result that is held back must stay put.
   `BIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // With no result waiting, the pipeline can always take a request.
   `BIS_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_tvalid, req_tready)

   // A register read straight after a write to it returns the written size bits.
   `BIS_ASSERT_NOW(a_csr_readback, clock, reset, readback_due, csr_prdata == csr_wdata_ff)

endmodule

bind bilinear_image_sampler bis_checker u_bis_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);

// File: test/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the bilinear image sampler.
//
// Requests go in on the req stream. A pixel-write request fills one entry of the image
// store and gives no result. A sample request gives one Q1.16 intensity on the rsp stream.
// Every accepted sample request is run through a predictor held here. The predictor has its
// own copy of the image and of the two size registers. The predicted intensity is queued and
// compared with the next result that the block hands over.
//
// The image store is undefined until it has been written, so no sample request may touch an
// unwritten pixel. The bench therefore keeps a map of the pixels it has written. It also keeps
// a list of every two-by-two patch whose four pixels are all known, and it only issues
// samples whose four neighbours, after clamping, form such a patch.
module tb;
   import bis_pkg::*;

   localparam int IMG_MAX        = 256;
   localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
   localparam int FRAC_ONE_I     = 1 << FRAC_BITS;
   localparam int UNIT           = 65536;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 52;

   // Two of the phases draw their sizes at random. The table entries for them are unused.
   localparam int RANDOM_WIDE_PHASE   = 9;
   localparam int RANDOM_NARROW_PHASE = 10;
   localparam int PHASE_W [PHASES] = '{2, 0, 511, 5, 16, 256, 2, 37, 257, 0, 0, 256};
   localparam int PHASE_H [PHASES] = '{2, 1, 300, 3, 9, 2, 256, 200, 1, 0, 0, 256};

   typedef struct packed {
      logic               kind;
      logic [PIX_W-1:0]   col;
      logic [PIX_W-1:0]   row;
      logic [PIX_W-1:0]   value;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic               has_want;
      logic [VALUE_W-1:0] want;
   } directed_row_type;

   // The directed opening runs at the reset sizes of 256 by 256. A row with has_want set
   // carries a result that can be worked out by hand. The other sample rows go through the
   // predictor. Negative coordinates are written as raw 18-bit patterns.
   localparam int DIRECTED_COUNT = 22;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // The top-left patch is set to full intensity.
      '{KIND_WRITE,  8'd0,   8'd0,   8'd255, 18'h00000, 18'h00000, 1'b0, 17'd0},
      '{KIND_WRITE,  8'd1,   8'd0,   8'd255, 18'h00000, 18'h00000, 1'b0, 17'd0},
      '{KIND_WRITE,  8'd0,   8'd1,   8'd255, 18'h00000, 18'h00000, 1'b0, 17'd0},
      '{KIND_WRITE,  8'd1,   8'd1,   8'd255, 18'h00000, 18'h00000, 1'b0, 17'd0},
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'h00000, 18'h00000, 1'b1, 17'd65536},
      // The most negative coordinate, then minus one. Both clamp to zero.
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'h20000, 18'h20000, 1'b1, 17'd65536},
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'h3FFFF, 18'h3FFFF, 1'b1, 17'd65536},
      // The bottom-right patch is set to black.
      '{KIND_WRITE,  8'd254, 8'd254, 8'd0,   18'h00000, 18'h00000, 1'b0, 17'd0},
      '{KIND_WRITE,  8'd255, 8'd254, 8'd0,   18'h00000, 18'h00000, 1'b0, 17'd0},
      '{KIND_WRITE,  8'd254, 8'd255, 8'd0,   18'h00000, 18'h00000, 1'b0, 17'd0},
      '{KIND_WRITE,  8'd255, 8'd255, 8'd0,   18'h00000, 18'h00000, 1'b0, 17'd0},
      // The largest coordinate, the exact top and just above the top all clamp to size - 2.
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'h1FFFF, 18'h1FFFF, 1'b1, 17'd0},
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'd65024, 18'd65024, 1'b1, 17'd0},
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'd65279, 18'd65279, 1'b1, 17'd0},
      // One dark corner in a bright patch gives true interpolation.
      '{KIND_WRITE,  8'd0,   8'd0,   8'd0,   18'h00000, 18'h00000, 1'b0, 17'd0},
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'd128,   18'd128,   1'b0, 17'd0},
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'd255,   18'd255,   1'b0, 17'd0},
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'd0,     18'd0,     1'b1, 17'd0},
      // A write with junk in its sample fields, then samples with junk in their pixel fields.
      '{KIND_WRITE,  8'd1,   8'd0,   8'd128, 18'h3FFFF, 18'h1FFFF, 1'b0, 17'd0},
      '{KIND_SAMPLE, 8'd255, 8'd255, 8'd255, 18'd255,   18'd0,     1'b0, 17'd0},
      '{KIND_SAMPLE, 8'd170, 8'd85,  8'd255, 18'd1,     18'd1,     1'b0, 17'd0},
      '{KIND_SAMPLE, 8'd0,   8'd0,   8'd0,   18'h3FFFB, 18'd255,   1'b0, 17'd0}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // The predictor's view of the block: the image, the size registers and the sizes they give.
   logic [PIX_W-1:0]      img_mem [IMG_MAX * IMG_MAX];
   logic [SIZE_REG_W-1:0] width_reg;
   logic [SIZE_REG_W-1:0] height_reg;
   int                    span_w;
   int                    span_h;

   // Bookkeeping that keeps sample requests away from pixels that were never written.
   bit pixel_known [IMG_MAX * IMG_MAX];
   bit anchor_seen [IMG_MAX * IMG_MAX];
   int anchor_list [$];

   logic [VALUE_W-1:0] pending_values [$];

   int unsigned requests_sent;
   int unsigned samples_sent;
   int unsigned writes_sent;
   int unsigned results_checked;
   int unsigned settings_tried;
   int unsigned failures;
   int unsigned quiet_cycles;
   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;
   bit          calm;

   bilinear_image_sampler #(
      .MAX_WIDTH  (IMG_MAX),
      .MAX_HEIGHT (IMG_MAX)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every failure is counted. Only the first ten are described, to keep the log short.
   function automatic void report_failure(input string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
   endfunction

   // A size register below two reads as two, and one above the store's size saturates.
   function automatic int eff_span(input logic [SIZE_REG_W-1:0] r);
      if (r < MIN_SIZE) return MIN_SIZE;
      if (r > IMG_MAX) return IMG_MAX;
      return int'(r);
   endfunction

   // This returns the coordinate clamped to 0 .. (span - 2) in fixed point. The integer part
   // picks the patch and the low FRAC_BITS are the weight.
   function automatic int clamp_axis(input logic [COORD_W-1:0] raw, input int span);
      int c;
      int top;
      c   = $signed(raw);
      top = (span - 2) << FRAC_BITS;
      if (c < 0) c = 0;
      if (c > top) c = top;
      return c;
   endfunction

   function automatic logic [VALUE_W-1:0] interpolate(input logic [COORD_W-1:0] sx,
                                                      input logic [COORD_W-1:0] sy);
      int     cx;
      int     cy;
      int     base;
      longint s;
      longint t;
      longint ws;
      longint wt;
      longint acc;
      longint den;
      longint q;
      cx   = clamp_axis(sx, span_w);
      cy   = clamp_axis(sy, span_h);
      base = (cy >> FRAC_BITS) * IMG_MAX + (cx >> FRAC_BITS);
      s    = cx % FRAC_ONE_I;
      t    = cy % FRAC_ONE_I;
      ws   = FRAC_ONE_I - s;
      wt   = FRAC_ONE_I - t;
      acc  = ws * wt * longint'(img_mem[base])
           + ws * t  * longint'(img_mem[base + IMG_MAX])
           + s  * wt * longint'(img_mem[base + 1])
           + s  * t  * longint'(img_mem[base + IMG_MAX + 1]);
      // The sum is scaled to Q1.16 and divided by 255 * one * one, rounding halves up.
      den  = longint'(255) << (2 * FRAC_BITS);
      q    = (acc * UNIT + den / 2) / den;
      if (q > UNIT) q = UNIT;
      return VALUE_W'(q);
   endfunction

   function automatic bit patch_known(input int ac, input int ar);
      int base;
      base = ar * IMG_MAX + ac;
      return pixel_known[base] && pixel_known[base + 1] &&
             pixel_known[base + IMG_MAX] && pixel_known[base + IMG_MAX + 1];
   endfunction

   // A written pixel can complete up to four patches, namely those that have it as a corner.
   function automatic void note_written(input int col, input int row);
      int ac;
      int ar;
      pixel_known[row * IMG_MAX + col] = 1'b1;
      for (int dr = 0; dr < 2; dr++) begin
         for (int dc = 0; dc < 2; dc++) begin
            ac = col - dc;
            ar = row - dr;
            if (ac >= 0 && ar >= 0 && ac <= IMG_MAX - 2 && ar <= IMG_MAX - 2 &&
                !anchor_seen[ar * IMG_MAX + ac] && patch_known(ac, ar)) begin
               anchor_seen[ar * IMG_MAX + ac] = 1'b1;
               anchor_list.insert(anchor_list.size(), ar * IMG_MAX + ac);
            end
         end
      end
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] pack_request(input logic [PIX_W-1:0] col,
                                                           input logic [PIX_W-1:0] row,
                                                           input logic [PIX_W-1:0] value,
                                                           input logic [COORD_W-1:0] sx,
                                                           input logic [COORD_W-1:0] sy);
      logic [REQ_TDATA_W-1:0] d;
      d = '0;
      d[COL_LSB +: PIX_W]     = col;
      d[ROW_LSB +: PIX_W]     = row;
      d[VALUE_LSB +: PIX_W]   = value;
      d[SX_LSB +: COORD_W]    = sx;
      d[SY_LSB +: COORD_W]    = sy;
      return d;
   endfunction

   // Black and full white come up often, so that both ends of the result range are hit.
   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // This gives one coordinate whose clamped integer part is the given anchor. At the low edge
   // it is often any negative number. At the high edge it is often anything up to the maximum.
   function automatic logic [COORD_W-1:0] axis_coord(input int anchor, input int span);
      int top;
      int pick;
      top  = (span - 2) << FRAC_BITS;
      pick = $urandom_range(0, 9);
      if (anchor == 0 && pick < 3) return COORD_W'(-1 - int'($urandom_range(0, COORD_MAX)));
      if (anchor == span - 2 && pick >= 7)
         return COORD_W'(top + int'($urandom_range(0, COORD_MAX - top)));
      case ($urandom_range(0, 3))
         0: return COORD_W'(anchor << FRAC_BITS);
         1: return COORD_W'((anchor << FRAC_BITS) + FRAC_ONE_I - 1);
         default: return COORD_W'((anchor << FRAC_BITS) + int'($urandom_range(0, 255)));
      endcase
   endfunction

   // The predictor is updated at the edge where the block takes the request.
   function automatic void apply_request(input logic kind, input logic [REQ_TDATA_W-1:0] d,
                                         input logic has_want, input logic [VALUE_W-1:0] want);
      int col;
      int row;
      requests_sent++;
      if (kind == KIND_WRITE) begin
         col = d[COL_LSB +: PIX_W];
         row = d[ROW_LSB +: PIX_W];
         img_mem[row * IMG_MAX + col] = d[VALUE_LSB +: PIX_W];
         note_written(col, row);
         writes_sent++;
      end else begin
         pending_values.insert(pending_values.size(), has_want ? want
                               : interpolate(d[SX_LSB +: COORD_W], d[SY_LSB +: COORD_W]));
         samples_sent++;
      end
   endfunction

   // The task is entered just after a falling edge. tvalid is left high after the handshake,
   // so back-to-back requests need no gap.
   task automatic push_request(input logic kind, input logic [REQ_TDATA_W-1:0] d,
                               input logic has_want, input logic [VALUE_W-1:0] want);
      bit taken;
      if (!calm && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= d;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_tready;
         if (taken) apply_request(kind, d, has_want, want);
         @(negedge clock);
      end
   endtask

   task automatic issue_write(input int col, input int row, input logic [PIX_W-1:0] value);
      push_request(KIND_WRITE, pack_request(PIX_W'(col), PIX_W'(row), value,
                   COORD_W'($urandom), COORD_W'($urandom)), 1'b0, '0);
   endtask

   task automatic write_patch(input int ac, input int ar);
      issue_write(ac, ar, pick_pixel());
      issue_write(ac + 1, ar, pick_pixel());
      issue_write(ac, ar + 1, pick_pixel());
      issue_write(ac + 1, ar + 1, pick_pixel());
   endtask

   task automatic issue_sample_at(input int ac, input int ar);
      push_request(KIND_SAMPLE, pack_request(PIX_W'($urandom), PIX_W'($urandom),
                   PIX_W'($urandom), axis_coord(ac, span_w), axis_coord(ar, span_h)), 1'b0, '0);
   endtask

   // Fully random coordinates are tried first now and then. They are kept only when they land
   // on a known patch. Otherwise a known patch that lies inside the current sizes is chosen, or,
   // if none is found and at times anyway, one of the four corners that each phase writes first.
   task automatic issue_sample();
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      int                 ac;
      int                 ar;
      int                 entry;
      bit                 found;
      found = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
         sx = COORD_W'($urandom);
         sy = COORD_W'($urandom);
         if (patch_known(clamp_axis(sx, span_w) >> FRAC_BITS,
                         clamp_axis(sy, span_h) >> FRAC_BITS)) begin
            push_request(KIND_SAMPLE, pack_request(PIX_W'($urandom), PIX_W'($urandom),
                         PIX_W'($urandom), sx, sy), 1'b0, '0);
            return;
         end
      end
      for (int tries = 0; tries < 8 && !found; tries++) begin
         entry = anchor_list[$urandom_range(0, anchor_list.size() - 1)];
         ac    = entry % IMG_MAX;
         ar    = entry / IMG_MAX;
         found = (ac <= span_w - 2) && (ar <= span_h - 2);
      end
      if (!found || $urandom_range(0, 3) == 0) begin
         ac = $urandom_range(0, 1) ? 0 : span_w - 2;
         ar = $urandom_range(0, 1) ? 0 : span_h - 2;
      end
      issue_sample_at(ac, ar);
   endtask

   // This waits for every outstanding result, then keeps waiting in case a write request
   // is still in the pipeline.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_values.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One register access: a setup phase, then an access phase that lasts until pready, then
   // an idle gap before the port may be used again.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Both sizes are written with junk in the unused upper bits, and each is then read back.
   task automatic set_image_size(input logic [SIZE_REG_W-1:0] w, input logic [SIZE_REG_W-1:0] h);
      logic [CSR_DATA_W-1:0]  back;
      logic [CSR_ADDR_W-1:0]  waddr;
      logic [CSR_ADDR_W-1:0]  haddr;
      waddr = {REG_IMAGE_WIDTH, 2'b00};
      haddr = {REG_IMAGE_HEIGHT, 2'b00};
      csr_access(1'b1, waddr, {(CSR_DATA_W - SIZE_REG_W)'($urandom), w}, back);
      width_reg = w;
      csr_access(1'b1, haddr, {(CSR_DATA_W - SIZE_REG_W)'($urandom), h}, back);
      height_reg = h;
      span_w = eff_span(width_reg);
      span_h = eff_span(height_reg);
      csr_access(1'b0, waddr, '0, back);
      if (back[SIZE_REG_W-1:0] !== width_reg)
         report_failure($sformatf("image_width read back %0d, expected %0d",
                                  back[SIZE_REG_W-1:0], width_reg));
      csr_access(1'b0, haddr, '0, back);
      if (back[SIZE_REG_W-1:0] !== height_reg)
         report_failure($sformatf("image_height read back %0d, expected %0d",
                                  back[SIZE_REG_W-1:0], height_reg));
      settings_tried++;
   endtask

   // The result side stalls in bursts. Within a phase the stall rate is fixed, and the last
   // phase has none.
   initial begin : result_sink
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Results are checked in order against the queue of predicted intensities.
   always @(posedge clock) begin : result_check
      logic [VALUE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_values.size() == 0) begin
            report_failure($sformatf("result %0d arrived with no sample request outstanding",
                                     rsp_tdata[VALUE_W-1:0]));
         end else begin
            want = pending_values.pop_front();
            results_checked++;
            if (rsp_tdata[VALUE_W-1:0] !== want)
               report_failure($sformatf("sample_value expected %0d, got %0d",
                                        want, rsp_tdata[VALUE_W-1:0]));
         end
      end
   end

   // The watchdog counts the cycles in which neither stream nor the register port moves.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      directed_row_type      drow;
      logic [SIZE_REG_W-1:0] w;
      logic [SIZE_REG_W-1:0] h;
      int unsigned           phase_goal;
      int                    pick;
      int                    ac;
      int                    ar;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = KIND_WRITE;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      reset         = 1'b1;
      calm          = 1'b0;
      req_idle_pct  = 10;
      rsp_stall_pct = 10;
      width_reg     = SIZE_REG_W'(SIZE_RESET);
      height_reg    = SIZE_REG_W'(SIZE_RESET);
      span_w        = eff_span(width_reg);
      span_h        = eff_span(height_reg);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The directed opening runs at the sizes that reset leaves.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         drow = DIRECTED_ROWS[i];
         push_request(drow.kind, pack_request(drow.col, drow.row, drow.value, drow.sx, drow.sy),
                      drow.has_want, drow.want);
      end
      drain_pipeline();

      // Each random phase sets new sizes while the block is idle and writes the four corner
      // patches. It then mixes samples with patch writes, each often followed at once by a
      // sample of the same patch, and with stray writes anywhere in the store.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            RANDOM_WIDE_PHASE: begin
               w = SIZE_REG_W'($urandom_range(0, 511));
               h = SIZE_REG_W'($urandom_range(0, 511));
            end
            RANDOM_NARROW_PHASE: begin
               w = SIZE_REG_W'($urandom_range(2, 24));
               h = SIZE_REG_W'($urandom_range(2, 24));
            end
            default: begin
               w = SIZE_REG_W'(PHASE_W[phase]);
               h = SIZE_REG_W'(PHASE_H[phase]);
            end
         endcase
         calm = (phase == PHASES - 1);
         case ($urandom_range(0, 3))
            0: req_idle_pct = 0;
            1: req_idle_pct = 3;
            2: req_idle_pct = 10;
            default: req_idle_pct = 30;
         endcase
         case ($urandom_range(0, 3))
            0: rsp_stall_pct = 0;
            1: rsp_stall_pct = 2;
            2: rsp_stall_pct = 8;
            default: rsp_stall_pct = 25;
         endcase
         set_image_size(w, h);
         write_patch(0, 0);
         write_patch(span_w - 2, 0);
         write_patch(0, span_h - 2);
         write_patch(span_w - 2, span_h - 2);
         phase_goal = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               issue_write($urandom_range(0, IMG_MAX - 1), $urandom_range(0, IMG_MAX - 1),
                           pick_pixel());
            end else if (pick < 28) begin
               ac = $urandom_range(0, span_w - 2);
               ar = $urandom_range(0, span_h - 2);
               write_patch(ac, ar);
               if ($urandom_range(0, 1)) issue_sample_at(ac, ar);
            end else begin
               issue_sample();
            end
         end
         drain_pipeline();
      end

      if (pending_values.size() != 0)
         report_failure($sformatf("%0d results never arrived", pending_values.size()));
      $display("covered %0d requests (%0d samples, %0d pixel writes) over %0d size settings",
               requests_sent, samples_sent, writes_sent, settings_tried + 1);
      $display("%0d results compared, %0d failures", results_checked, failures);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
